/* rtl/core/lkvc_pkg.sv */
// lkvc_pkg: shared types and constants for the LRU key-value cache.
// Used by lkvc_ctrl, lkvc_dpath and lru_key_value_cache; no dependencies.

package lkvc_pkg;

	// operation codes carried on the input tuser bit
	localparam logic KIND_GET = 1'b0;
	localparam logic KIND_PUT = 1'b1;

	// field widths fixed by the item format
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CAP_W = 5;

	// capacity after reset
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load_in;   // capture an accepted input item
		logic update;    // match keys and update the store
		logic load_out;  // move the result into the output register
	} lkvc_cmd_t;

endpackage

/* rtl/core/lkvc_ctrl.sv */
// lkvc_ctrl: sequencer for the LRU key-value cache (accept, match, respond).
// Depends on lkvc_pkg for the command struct.

module lkvc_ctrl
	import lkvc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	output lkvc_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MATCH = 2'd1;
	localparam logic [1:0] ST_RESP  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       can_load;

	// output register is free, or is being emptied this cycle
	assign can_load = !out_valid_q || m_tready;

	// next state and commands
	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		cmd.load_in  = 1'b0;
		cmd.update   = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_MATCH;
				end
			end
			ST_MATCH: begin
				cmd.update = 1'b1;
				state_d    = ST_RESP;
			end
			ST_RESP: begin
				s_tready = can_load;
				if (can_load) begin
					cmd.load_out = 1'b1;
					if (s_tvalid) begin
						cmd.load_in = 1'b1;
						state_d     = ST_MATCH;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// advance state and track the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

	// the store update always follows straight after an item is captured
	a_match_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_in |=> cmd.update)
		else $error("store update did not follow input capture");

	// a match cycle always hands over to the response state
	a_match_to_resp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MATCH |=> state_q == ST_RESP)
		else $error("match cycle not followed by response");

	// no new item while the store is being updated
	a_no_accept_in_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> !s_tready)
		else $error("input accepted during store update");

	// a loaded result is presented on the next cycle
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> m_tvalid)
		else $error("loaded result not presented");

endmodule

/* rtl/core/lkvc_dpath.sv */
// lkvc_dpath: key match array, recency ranks, value memory and output register.
// Depends on lkvc_pkg for widths, operation codes and the command struct.

module lkvc_dpath
	import lkvc_pkg::*;
#(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lkvc_cmd_t               cmd,
	input  logic                    cfg_we,
	input  logic [CAP_W-1:0]        cfg_wdata,
	input  logic                    in_kind,
	input  logic signed [KEY_W-1:0] in_key,
	input  logic signed [VAL_W-1:0] in_value,
	output logic                    hit,
	output logic signed [VAL_W-1:0] read_value
);

	localparam int IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW   = $clog2(MAX_ENTRIES + 1);
	localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

	logic [CAP_W-1:0]        capacity_q;
	logic                    kind_q;
	logic [KEY_W-1:0]        key_q;
	logic [VAL_W-1:0]        val_q;
	logic [KEY_W-1:0]        keys_q  [MAX_ENTRIES];
	logic [IW-1:0]           rank_q  [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0]  valid_q;
	logic [CW-1:0]           count_q;
	logic [VAL_W-1:0]        val_mem [MAX_ENTRIES];
	logic [VAL_W-1:0]        rd_q;
	logic                    hit_q;
	logic                    get_hit_q;
	logic                    hit_out_q;
	logic [VAL_W-1:0]        rv_out_q;

	logic [MAX_ENTRIES-1:0]  hit_vec;
	logic [MAX_ENTRIES-1:0]  victim_vec;
	logic [IW-1:0]           found_idx;
	logic [IW-1:0]           victim_idx;
	logic [IW-1:0]           free_idx;
	logic [IW-1:0]           hit_rank;
	logic [CMPW-1:0]         eff_cap;
	logic                    any_hit;
	logic                    is_put;
	logic                    full;
	logic                    touch;
	logic                    age_all;
	logic                    ins;
	logic                    wr_key;
	logic                    wr_val;
	logic [IW-1:0]           slot;
	logic [IW-1:0]           thr;
	logic [IW-1:0]           oldest_rank;

	// clamp capacity to one .. MAX_ENTRIES
	always_comb begin
		if (capacity_q == '0) begin
			eff_cap = CMPW'(1);
		end else if (CMPW'(capacity_q) > CMPW'(MAX_ENTRIES)) begin
			eff_cap = CMPW'(MAX_ENTRIES);
		end else begin
			eff_cap = CMPW'(capacity_q);
		end
	end

	assign full        = CMPW'(count_q) >= eff_cap;
	assign is_put      = (kind_q == KIND_PUT);
	assign oldest_rank = IW'(count_q - CW'(1));

	// compare the key against every entry; find the oldest entry
	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			hit_vec[i]    = valid_q[i] && (keys_q[i] == key_q);
			victim_vec[i] = valid_q[i] && (rank_q[i] == oldest_rank);
		end
	end

	assign any_hit = |hit_vec;

	// encode the lowest matching, oldest and free slots
	always_comb begin
		found_idx  = '0;
		victim_idx = '0;
		free_idx   = '0;
		hit_rank   = '0;
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				found_idx = IW'(i);
			end
			if (victim_vec[i]) begin
				victim_idx = IW'(i);
			end
			if (!valid_q[i]) begin
				free_idx = IW'(i);
			end
		end
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (hit_vec[i]) begin
				hit_rank = hit_rank | rank_q[i];
			end
		end
	end

	// pick the slot to touch and what to write there
	always_comb begin
		touch   = 1'b0;
		age_all = 1'b0;
		ins     = 1'b0;
		wr_key  = 1'b0;
		wr_val  = 1'b0;
		slot    = found_idx;
		thr     = hit_rank;
		priority if (any_hit) begin
			touch  = 1'b1;
			wr_val = is_put;
		end else if (is_put && full) begin
			touch  = 1'b1;
			wr_key = 1'b1;
			wr_val = 1'b1;
			slot   = victim_idx;
			thr    = oldest_rank;
		end else if (is_put) begin
			touch   = 1'b1;
			age_all = 1'b1;
			ins     = 1'b1;
			wr_key  = 1'b1;
			wr_val  = 1'b1;
			slot    = free_idx;
		end else begin
			// get miss: leave the store as it is
			touch = 1'b0;
		end
	end

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	// capture the accepted item
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q <= in_kind;
			key_q  <= in_key;
			val_q  <= in_value;
		end
	end

	// age entries, mark the touched one most recent, track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (cmd.update && touch) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (IW'(i) == slot) begin
					rank_q[i] <= '0;
				end else if (valid_q[i] && (age_all || rank_q[i] < thr)) begin
					rank_q[i] <= rank_q[i] + IW'(1);
				end
			end
			if (ins) begin
				valid_q[slot] <= 1'b1;
				count_q       <= count_q + CW'(1);
			end
		end
	end

	// key store
	always_ff @(posedge clk) begin
		if (cmd.update && wr_key) begin
			keys_q[slot] <= key_q;
		end
	end

	// value memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.update && wr_val) begin
			val_mem[slot] <= val_q;
		end
		if (cmd.update) begin
			rd_q <= val_mem[found_idx];
		end
	end

	// hold the lookup outcome for the response cycle
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			hit_q     <= any_hit;
			get_hit_q <= any_hit && !is_put;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			hit_out_q <= hit_q;
			rv_out_q  <= get_hit_q ? rd_q : '0;
		end
	end

	assign hit        = hit_out_q;
	assign read_value = rv_out_q;

endmodule

/* rtl/core/lru_key_value_cache.sv */
// lru_key_value_cache: top level of the key-value cache with LRU replacement.
// Instantiates lkvc_ctrl and lkvc_dpath; depends on lkvc_pkg.
//
//   channel  | direction | payload
//   ---------+-----------+--------------------------------------------------
//   s_axis   | in        | tdata: key[31:0], value[63:32]; tuser: kind
//   m_axis   | out       | tdata: read_value[31:0]; tuser: hit
//   cfg      | in        | cfg_wdata: capacity, written when cfg_we is high
//
// Each item is captured when accepted; in the match state its key is matched
// against all entries while ranks, keys and the value memory update; in the
// response state the result moves from the value memory's registered read port
// into the output register while the next item may be accepted; a stalled
// output holds the block there. After reset the store is empty, capacity 16.

module lru_key_value_cache
	import lkvc_pkg::*;
#(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [KEY_W+VAL_W-1:0]    s_tdata,   // key, value
	input  logic                      s_tuser,   // kind
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [VAL_W-1:0]          m_tdata,   // read_value
	output logic                      m_tuser,   // hit
	input  logic                      cfg_we,
	input  logic [CAP_W-1:0]          cfg_wdata  // capacity
);

	lkvc_cmd_t               cmd;
	logic signed [VAL_W-1:0] read_value;

	// sequencer
	lkvc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// store and result path
	lkvc_dpath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_kind    (s_tuser),
		.in_key     (s_tdata[KEY_W-1:0]),
		.in_value   (s_tdata[KEY_W+VAL_W-1:KEY_W]),
		.hit        (m_tuser),
		.read_value (read_value)
	);

	assign m_tdata = read_value;

endmodule

/* tb/sv/lkvc_checker.sv */
// lkvc_checker: watches the input, output and configuration channels of the
// LRU key-value cache, predicts every lookup result and compares it.
// Depends on lkvc_pkg for field widths, operation codes and the reset capacity.

module lkvc_checker
	import lkvc_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [KEY_W+VAL_W-1:0] s_tdata,   // key, value
	input  logic                   s_tuser,   // kind
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [VAL_W-1:0]       m_tdata,   // read_value
	input  logic                   m_tuser,   // hit
	input  logic                   cfg_we,
	input  logic [CAP_W-1:0]       cfg_wdata, // capacity
	output int                     fail_count,
	output int                     pending,
	output int                     result_count,
	output int                     hit_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] read_value;
	} lookup_result_t;

	// predicted contents of the store
	logic [KEY_W-1:0] slot_key   [SLOTS];
	logic [VAL_W-1:0] slot_val   [SLOTS];
	logic             slot_valid [SLOTS];
	logic [3:0]       slot_rank  [SLOTS];
	logic [4:0]       entry_count;
	logic [CAP_W-1:0] cap_reg;

	lookup_result_t   result_q[$];
	lookup_result_t   want;

	// clamp the programmed capacity to 1..SLOTS
	function automatic int eff_capacity();
		int c;
		c = int'(cap_reg);
		if (c == 0)
			c = 1;
		if (c > SLOTS)
			c = SLOTS;
		return c;
	endfunction

	// make slot s most recent; newer valid entries age by one
	function automatic void promote(int s);
		logic [3:0] r;
		r = slot_rank[s];
		for (int i = 0; i < SLOTS; i++) begin
			if (i != s && slot_valid[i] && slot_rank[i] < r)
				slot_rank[i]++;
		end
		slot_rank[s] = '0;
	endfunction

	// apply one get or put to the predicted store and return its result
	function automatic lookup_result_t access_cache(logic kind, logic [KEY_W-1:0] key,
			logic [VAL_W-1:0] value);
		lookup_result_t res;
		logic           found;
		logic           placed;
		int             slot;
		int             victim;
		res    = '0;
		found  = 1'b0;
		placed = 1'b0;
		slot   = 0;
		victim = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (!found && slot_valid[i] && slot_key[i] == key) begin
				found = 1'b1;
				slot  = i;
			end
		end
		if (found) begin
			promote(slot);
			if (kind == KIND_GET)
				res.read_value = slot_val[slot];
			else
				slot_val[slot] = value;
		end else if (kind == KIND_PUT) begin
			if (int'(entry_count) >= eff_capacity()) begin
				// full: reuse the slot of the least recent entry
				for (int i = 0; i < SLOTS; i++) begin
					if (slot_valid[i] && (victim < 0 || slot_rank[i] > slot_rank[victim]))
						victim = i;
				end
				if (victim >= 0) begin
					promote(victim);
					slot_key[victim] = key;
					slot_val[victim] = value;
				end
			end else begin
				// room left: take the lowest free slot, everything else ages
				for (int i = 0; i < SLOTS; i++) begin
					if (!placed && !slot_valid[i]) begin
						placed = 1'b1;
						slot   = i;
					end
				end
				if (placed) begin
					for (int i = 0; i < SLOTS; i++) begin
						if (slot_valid[i])
							slot_rank[i]++;
					end
					slot_key[slot]   = key;
					slot_val[slot]   = value;
					slot_rank[slot]  = '0;
					slot_valid[slot] = 1'b1;
					entry_count++;
				end
			end
		end
		res.hit = found;
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] exp_val, logic [31:0] got_val);
		$display("%0t ns: mismatch on %s: expected %h, got %h", $time, what, exp_val, got_val);
		fail_count++;
	endtask

	// follow the channels: retire results first, then predict new items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_valid[i] = 1'b0;
				slot_rank[i]  = '0;
			end
			entry_count  = '0;
			cap_reg      = CAP_RESET;
			result_q.delete();
			fail_count   = 0;
			result_count = 0;
			hit_count    = 0;
			pending      = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (result_q.size() == 0) begin
					report_mismatch("result with no item outstanding", '0, m_tdata);
				end else begin
					want = result_q.pop_front();
					if (m_tuser !== want.hit)
						report_mismatch("hit", {31'b0, want.hit}, {31'b0, m_tuser});
					if (m_tdata !== want.read_value)
						report_mismatch("read_value", want.read_value, m_tdata);
					result_count++;
					if (want.hit)
						hit_count++;
				end
			end
			if (s_tvalid && s_tready)
				result_q.push_back(access_cache(s_tuser, s_tdata[KEY_W-1:0],
					s_tdata[KEY_W+VAL_W-1:KEY_W]));
			if (cfg_we)
				cap_reg = cfg_wdata;
			pending = result_q.size();
		end
	end

endmodule

/* tb/sv/tb_top.sv */
// tb_top: stimulus and verdict for the LRU key-value cache.
// Drives lru_key_value_cache and lkvc_checker; depends on lkvc_pkg.

module tb_top
	import lkvc_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int POOL_MAX       = 24;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [KEY_W+VAL_W-1:0] s_tdata   = '0;      // key, value
	logic                   s_tuser   = KIND_GET; // kind
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [VAL_W-1:0]       m_tdata;             // read_value
	logic                   m_tuser;             // hit
	logic                   cfg_we    = 1'b0;
	logic [CAP_W-1:0]       cfg_wdata = '0;      // capacity

	int fail_count;
	int pending;
	int result_count;
	int hit_count;

	bit               idle_on       = 1'b0;
	bit               quiet         = 1'b0;
	int               stall_left    = 0;
	int               idle_cycles   = 0;
	int               settings_done = 0;
	int               pool_size     = 1;
	logic [KEY_W-1:0] key_pool[POOL_MAX];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	lru_key_value_cache #(
		.MAX_ENTRIES(16)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	lkvc_checker #(
		.SLOTS(16)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.fail_count   (fail_count),
		.pending      (pending),
		.result_count (result_count),
		.hit_count    (hit_count)
	);

	// stall the output side in random bursts while idle_on is set
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			stall_left = $urandom_range(0, 5);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t ns: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// offer one item, after an optional gap, and hold it until accepted
	task automatic send_access(logic kind, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {value, key};
		s_tuser  <= kind;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// drain the block, then write the capacity register
	task automatic write_capacity(logic [CAP_W-1:0] cap);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we    <= 1'b0;
		settings_done++;
	endtask

	// one capacity setting with random accesses over a small key pool
	task automatic run_phase(logic [CAP_W-1:0] cap, int n_items);
		logic [KEY_W-1:0] key;
		write_capacity(cap);
		if (cap == 0)
			pool_size = 3;
		else if (cap > 16)
			pool_size = 20;
		else
			pool_size = int'(cap) + 1 + $urandom_range(0, 3);
		for (int p = 0; p < POOL_MAX; p++)
			key_pool[p] = $urandom;
		for (int i = 0; i < n_items; i++) begin
			if (i % 35 == 0)
				idle_on = !quiet && ($urandom_range(0, 3) != 0);
			// mostly reused keys so hits and evictions happen; some stray keys
			if ($urandom_range(0, 9) == 0)
				key = $urandom;
			else
				key = key_pool[$urandom_range(0, pool_size - 1)];
			send_access(1'($urandom_range(0, 1)), key, $urandom);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store, extreme keys and values, put hit, ignored get value
		send_access(KIND_GET, 32'h0000_0000, 32'h0000_0000);
		send_access(KIND_PUT, 32'h8000_0000, 32'h7fff_ffff);
		send_access(KIND_PUT, 32'h7fff_ffff, 32'h8000_0000);
		send_access(KIND_PUT, 32'h0000_0000, 32'h0000_0000);
		send_access(KIND_PUT, 32'hffff_ffff, 32'hffff_ffff);
		send_access(KIND_GET, 32'h8000_0000, 32'hdead_beef);
		send_access(KIND_GET, 32'h7fff_ffff, 32'h0000_0000);
		send_access(KIND_GET, 32'h0000_0000, 32'hffff_ffff);
		send_access(KIND_GET, 32'hffff_ffff, 32'h0000_0000);
		send_access(KIND_PUT, 32'hffff_ffff, 32'h1234_5678);
		send_access(KIND_GET, 32'hffff_ffff, 32'h0000_0000);
		send_access(KIND_GET, 32'h0000_0001, 32'h0000_0000);

		// zero capacity acts as one, with the store already above it
		write_capacity(5'd0);
		send_access(KIND_PUT, 32'h0000_0001, 32'h5555_5555);
		send_access(KIND_GET, 32'h8000_0000, 32'h0000_0000);
		send_access(KIND_PUT, 32'h0000_0002, 32'haaaa_aaaa);
		send_access(KIND_GET, 32'h0000_0002, 32'h0000_0000);
		send_access(KIND_GET, 32'h0000_0001, 32'h0000_0000);

		// oversized capacity acts as the full store; fill free slots
		write_capacity(5'd31);
		send_access(KIND_PUT, 32'h0000_000a, 32'h0000_0001);
		send_access(KIND_PUT, 32'h0000_000b, 32'h0000_0002);
		send_access(KIND_PUT, 32'h0000_000c, 32'h0000_0003);
		send_access(KIND_GET, 32'h0000_000a, 32'h0000_0000);
		send_access(KIND_GET, 32'h0000_0002, 32'h0000_0000);

		// random part over a range of capacities, quiet at the end
		run_phase(5'd2,  70);
		run_phase(5'd1,  70);
		run_phase(5'd16, 70);
		run_phase(5'd0,  70);
		run_phase(5'd3,  70);
		run_phase(5'd31, 70);
		run_phase(5'd8,  70);
		run_phase(5'd5,  70);
		quiet   = 1'b1;
		idle_on = 1'b0;
		run_phase(5'd17, 70);
		run_phase(5'd4,  70);

		// drain and let the block settle
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Covered %0d accesses, %0d of them hits, across %0d capacity settings",
			result_count, hit_count, settings_done + 1);
		$display("with random stalls on both channels and a final stretch at full rate.");
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

/* lru_key_value_cache.f */
rtl/core/lkvc_pkg.sv
rtl/core/lkvc_ctrl.sv
rtl/core/lkvc_dpath.sv
rtl/core/lru_key_value_cache.sv
tb/sv/lkvc_checker.sv
tb/sv/tb_top.sv
